### rtl/core/sk64_pkg.sv
// ----------------------------------------------------------------------------
// sk64_pkg
// Shared types, constants and round functions for the SKINNY-64-64 pipeline.
// ----------------------------------------------------------------------------
package sk64_pkg;

  localparam int BLOCK_W = 64;
  localparam int SK64_ROUNDS = 32;

  // operation codes
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef logic [3:0] nibble_t;

  // control that travels with each transaction through the stages
  typedef struct packed {
    logic valid;
    logic op;
  } sk64_ctl_t;

  localparam nibble_t SBOX_FWD [16] = '{
    4'hC, 4'h6, 4'h9, 4'h0, 4'h1, 4'hA, 4'h2, 4'hB,
    4'h3, 4'h8, 4'h5, 4'hD, 4'h4, 4'hE, 4'h7, 4'hF
  };
  localparam nibble_t SBOX_INV [16] = '{
    4'h3, 4'h4, 4'h6, 4'h8, 4'hC, 4'hA, 4'h1, 4'hE,
    4'h9, 4'h2, 4'h5, 4'h7, 4'h0, 4'hB, 4'hD, 4'hF
  };
  localparam int TK_PERM [16] = '{9, 15, 8, 13, 10, 14, 12, 11,
                                   0, 1, 2, 3, 4, 5, 6, 7};
  localparam int SHIFT_SRC [16] = '{0, 1, 2, 3, 7, 4, 5, 6,
                                     10, 11, 8, 9, 13, 14, 15, 12};
  localparam nibble_t RC_CELL8 = 4'h2;

  // round constant of round r (lfsr stepped r+1 times from zero)
  function automatic logic [5:0] round_const(input int r);
    logic [5:0] rc;
    rc = '0;
    for (int k = 0; k <= r; k++) begin
      rc = {rc[4:0], rc[5] ^ rc[4] ^ 1'b1};
    end
    return rc;
  endfunction

  function automatic logic [63:0] sub_cells(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 16; i++) begin
      r[4*i +: 4] = SBOX_FWD[v[4*i +: 4]];
    end
    return r;
  endfunction

  function automatic logic [63:0] sub_cells_inv(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 16; i++) begin
      r[4*i +: 4] = SBOX_INV[v[4*i +: 4]];
    end
    return r;
  endfunction

  // round constant and top two rows of the tweakey
  function automatic logic [63:0] add_rtk(input logic [63:0] v, input logic [5:0] rc,
                                          input logic [63:0] tk);
    logic [63:0] r;
    r = v ^ {tk[63:32], 32'h0};
    r[63:60] = r[63:60] ^ rc[3:0];
    r[47:44] = r[47:44] ^ {2'b00, rc[5:4]};
    r[31:28] = r[31:28] ^ RC_CELL8;
    return r;
  endfunction

  function automatic logic [63:0] shift_rows(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 16; i++) begin
      r[60-4*i +: 4] = v[60-4*SHIFT_SRC[i] +: 4];
    end
    return r;
  endfunction

  function automatic logic [63:0] shift_rows_inv(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 16; i++) begin
      r[60-4*SHIFT_SRC[i] +: 4] = v[60-4*i +: 4];
    end
    return r;
  endfunction

  function automatic logic [63:0] mix_cols(input logic [63:0] v);
    logic [15:0] r0, r1, r2, r3;
    {r0, r1, r2, r3} = v;
    return {r0 ^ r2 ^ r3, r0, r1 ^ r2, r0 ^ r2};
  endfunction

  function automatic logic [63:0] mix_cols_inv(input logic [63:0] v);
    logic [15:0] r0, r1, r2, r3;
    {r0, r1, r2, r3} = v;
    return {r1, r1 ^ r2 ^ r3, r1 ^ r3, r0 ^ r3};
  endfunction

  // tweakey cell permutation
  function automatic logic [63:0] tk_permute(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 16; i++) begin
      r[60-4*i +: 4] = v[60-4*TK_PERM[i] +: 4];
    end
    return r;
  endfunction

endpackage

### rtl/core/sk64_stage.sv
// ----------------------------------------------------------------------------
// sk64_stage
// One pipeline stage: a forward or inverse round and its output register.
// ----------------------------------------------------------------------------
module sk64_stage #(
  parameter int ROUNDS = sk64_pkg::SK64_ROUNDS,
  parameter int STAGE  = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sk64_pkg::sk64_ctl_t          ctl_i,
  input  logic [sk64_pkg::BLOCK_W-1:0] data_i,
  output logic                         ready_o,
  input  logic [sk64_pkg::BLOCK_W-1:0] tk_enc_i,
  input  logic [sk64_pkg::BLOCK_W-1:0] tk_dec_i,
  output sk64_pkg::sk64_ctl_t          ctl_o,
  output logic [sk64_pkg::BLOCK_W-1:0] data_o,
  input  logic                         ready_i
);
  import sk64_pkg::*;

  // encryption runs round STAGE, decryption the mirrored round
  localparam logic [5:0] RcEnc = round_const(STAGE);
  localparam logic [5:0] RcDec = round_const(ROUNDS - 1 - STAGE);

  sk64_ctl_t          ctl_q;
  logic [BLOCK_W-1:0] data_q, data_d;
  logic [BLOCK_W-1:0] enc_rnd, dec_rnd;

  // round logic
  always_comb begin
    enc_rnd = mix_cols(shift_rows(add_rtk(sub_cells(data_i), RcEnc, tk_enc_i)));
    dec_rnd = sub_cells_inv(add_rtk(shift_rows_inv(mix_cols_inv(data_i)), RcDec, tk_dec_i));
    data_d  = (ctl_i.op == OP_DECRYPT) ? dec_rnd : enc_rnd;
  end

  // stage takes a transaction when empty or when its content moves on
  assign ready_o = !ctl_q.valid || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (ready_o) begin
      ctl_q <= ctl_i;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (ready_o && ctl_i.valid) begin
      data_q <= data_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign data_o = data_q;

endmodule

### rtl/core/skinny64_block_cipher.sv
// ----------------------------------------------------------------------------
// skinny64_block_cipher
// SKINNY-64-64 encrypt/decrypt engine, one round per pipeline stage.
// ----------------------------------------------------------------------------
// Usage:
//  - the key is written through key_we_i/key_wdata_i; write it only while no
//    transaction is in flight. Reset sets the key to zero.
//  - input transaction: opcode_i (0 encrypt, 1 decrypt) and block_in_i, taken
//    when in_valid_i is high and in_stall_o is low.
//  - output transaction: block_out_o, taken when out_valid_o is high and
//    out_stall_i is low.
//  - one register stage per round; a new block is accepted every cycle while
//    in_stall_o is low, encrypts and decrypts mixed freely.
//  - while the receiver stalls, stages keep filling: blocks move forward
//    into empty stages, and in_stall_o rises only when every stage holds a
//    block. The held result stays on block_out_o unchanged.
//  - reset empties the pipeline; nothing is in flight afterwards.
// ----------------------------------------------------------------------------
module skinny64_block_cipher #(
  parameter int ROUNDS = sk64_pkg::SK64_ROUNDS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         key_we_i,
  input  logic [sk64_pkg::BLOCK_W-1:0] key_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         opcode_i,
  input  logic [sk64_pkg::BLOCK_W-1:0] block_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sk64_pkg::BLOCK_W-1:0] block_out_o
);
  import sk64_pkg::*;

  logic [BLOCK_W-1:0] key_q;
  logic [BLOCK_W-1:0] tk_sched [ROUNDS];
  sk64_ctl_t          ctl_s    [ROUNDS+1];
  logic [BLOCK_W-1:0] data_s   [ROUNDS+1];
  logic [ROUNDS:0]    ready_s;
  logic [ROUNDS-1:0]  valid_vec;

  // key register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (key_we_i) begin
      key_q <= key_wdata_i;
    end
  end

  // tweakey of each round: repeated cell permutation of the key
  assign tk_sched[0] = key_q;
  for (genvar r = 1; r < ROUNDS; r++) begin : g_tk
    assign tk_sched[r] = tk_permute(tk_sched[r-1]);
  end

  // pipeline entry and exit
  assign ctl_s[0].valid   = in_valid_i;
  assign ctl_s[0].op      = opcode_i;
  assign data_s[0]        = block_in_i;
  assign ready_s[ROUNDS]  = !out_stall_i;
  assign in_stall_o       = !ready_s[0];
  assign out_valid_o      = ctl_s[ROUNDS].valid;
  assign block_out_o      = data_s[ROUNDS];

  // round stages
  for (genvar j = 0; j < ROUNDS; j++) begin : g_stage
    sk64_stage #(
      .ROUNDS(ROUNDS),
      .STAGE (j)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_s[j]),
      .data_i  (data_s[j]),
      .ready_o (ready_s[j]),
      .tk_enc_i(tk_sched[j]),
      .tk_dec_i(tk_sched[ROUNDS-1-j]),
      .ctl_o   (ctl_s[j+1]),
      .data_o  (data_s[j+1]),
      .ready_i (ready_s[j+1])
    );
    assign valid_vec[j] = ctl_s[j+1].valid;
  end

  // input is held off only with every stage occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_vec))
    else $error("input stalled with an empty stage");

  // an accepted transaction lands in the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_vec[0])
    else $error("accepted transaction lost at pipeline entry");

  // occupancy grows by at most one per cycle
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones(valid_vec) <= $past($countones(valid_vec)) + 1))
    else $error("pipeline occupancy jumped");

  // the last stage keeps its transaction until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && ctl_s[ROUNDS].op == $past(ctl_s[ROUNDS].op)))
    else $error("stalled result dropped");

endmodule
